// File: rtl/phtam_pkg.sv
// Shared types and constants for the pH and temperature alarm monitor.
// Holds the payload structs, register index codes and fixed alarm timing.
// No dependencies.
`default_nettype none

package phtam_pkg;

  // Converter sample width; the input beat carries the sample at this width.
  localparam int unsigned ADC_BITS   = 16;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;

  // pH scale in milli-pH.
  localparam int unsigned PH_MID     = 7000;
  localparam int unsigned PH_MAX     = 14000;

  // Buzzer cycle timing in milliseconds.
  localparam logic [31:0] TONE_MS    = 32'd6000;
  localparam logic [31:0] CYCLE_MS   = 32'd16000;
  localparam logic [31:0] TOGGLE_MS  = 32'd1000;

  // Temperature code reported by a disconnected sensor (-127.0 C).
  localparam logic signed [11:0] TEMP_FAULT = -12'sd2032;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PH7_CODE = 3'd0,
    CFG_PH_SLOPE = 3'd1,
    CFG_MIN_PH   = 3'd2,
    CFG_MAX_PH   = 3'd3,
    CFG_MIN_TEMP = 3'd4,
    CFG_MAX_TEMP = 3'd5
  } cfg_reg_e;

  // One input sample.
  typedef struct packed {
    logic        [31:0]         now_ms;
    logic signed [ADC_BITS-1:0] adc_code;
    logic signed [11:0]         temp_sixteenths;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [13:0] ph_milli;
    logic        ph_unsafe;
    logic        buzzer_on;
    logic        led_red;
    logic        led_green;
    logic        led_blue;
    logic        sensor_fault;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/ph_temperature_alarm_monitor_core.sv
// pH and temperature alarm monitor, top level.
// Depends on phtam_pkg for the payload structs, register codes and timing.
//
// The block takes one sample per clock while the input is not stalled, and
// returns one result per sample, in order. The accepted sample beat goes into
// the input register, and its result then loads into the result register
// whenever the output is not stalled. Between the input register and the result register
// one combinational pass forms the signed product of the calibrated ADC offset
// and the Q16 slope (one multiplier), turns it into saturated milli-pH, checks
// the window, runs the buzzer cycle state and picks the LEDs. A stalled output
// only holds up the input once both registers are full, so the input keeps
// taking beats while a bubble remains. Configuration writes are always
// accepted and take effect on the next sample.
`default_nettype none

module ph_temperature_alarm_monitor_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Sample channel.
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire phtam_pkg::in_item_t           in_item_i,
  // Result channel.
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      phtam_pkg::out_item_t          out_item_o,
  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [phtam_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [phtam_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import phtam_pkg::*;

  localparam int unsigned DIFF_W = ((ADC_BITS > 16) ? ADC_BITS : 16) + 1;
  localparam int unsigned PROD_W = DIFF_W + CFG_DATA_W;
  localparam int unsigned Q_W    = PROD_W - 16;

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
    logic fault;
  } leds_t;

  // Configuration registers.
  logic        [14:0] ph7_code_q;
  logic signed [20:0] ph_slope_q;
  logic        [13:0] min_ph_q;
  logic        [13:0] max_ph_q;
  logic signed [11:0] min_temp_q;
  logic signed [11:0] max_temp_q;

  // Input and result registers.
  logic                     a_valid_q;
  in_item_t                 a_item_q;
  logic                     out_valid_q;
  out_item_t                out_item_q;

  // Buzzer cycle state.
  logic        alarm_q, alarm_d;
  logic [31:0] cycle_start_q, cycle_start_d;
  logic [31:0] last_toggle_q, last_toggle_d;
  logic        phase_q, phase_d;
  logic        buzz_q, buzz_d;

  logic load_a, load_c;
  logic en_c;

  // Register enables: a register loads when it is empty or its content moves on.
  assign en_c   = !out_valid_q || !out_stall_i;
  assign load_a = !a_valid_q || en_c;
  assign load_c = en_c;

  assign in_stall_o  = !load_a;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph7_code_q <= 15'd15000;
      ph_slope_q <= -21'sd47489;
      min_ph_q   <= 14'd6000;
      max_ph_q   <= 14'd8500;
      min_temp_q <= 12'sd320;
      max_temp_q <= 12'sd400;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PH7_CODE: ph7_code_q <= cfg_data_i[14:0];
        CFG_PH_SLOPE: ph_slope_q <= $signed(cfg_data_i);
        CFG_MIN_PH:   min_ph_q   <= cfg_data_i[13:0];
        CFG_MAX_PH:   max_ph_q   <= cfg_data_i[13:0];
        CFG_MIN_TEMP: min_temp_q <= $signed(cfg_data_i[11:0]);
        CFG_MAX_TEMP: max_temp_q <= $signed(cfg_data_i[11:0]);
        default: ;
      endcase
    end
  end

  // Input register: capture the sample beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (load_a) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_a && in_valid_i) begin
      a_item_q <= in_item_i;
    end
  end

  // Calibrated offset times slope, and the LED choice.
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  leds_t                    leds;

  always_comb begin
    diff = $signed({{(DIFF_W-ADC_BITS){a_item_q.adc_code[ADC_BITS-1]}}, a_item_q.adc_code})
         - $signed({{(DIFF_W-15){1'b0}}, ph7_code_q});
    prod = diff * ph_slope_q;

    leds = '0;
    if (a_item_q.temp_sixteenths == TEMP_FAULT) begin
      leds.fault = 1'b1;
    end else if (a_item_q.temp_sixteenths < min_temp_q) begin
      leds.blue = 1'b1;
    end else if (a_item_q.temp_sixteenths > max_temp_q) begin
      leds.red = 1'b1;
    end else begin
      leds.green = 1'b1;
    end
  end

  // Floor shift, offset, saturation and the window check.
  logic signed [Q_W-1:0] q_val;
  logic signed [Q_W:0]   ph_sum;
  logic        [13:0]    ph_milli;
  logic                  unsafe;

  always_comb begin
    q_val  = prod[PROD_W-1:16];
    ph_sum = $signed({q_val[Q_W-1], q_val}) + $signed((Q_W+1)'(PH_MID));
    if (ph_sum < 0) begin
      ph_milli = '0;
    end else if (ph_sum > $signed((Q_W+1)'(PH_MAX))) begin
      ph_milli = 14'(PH_MAX);
    end else begin
      ph_milli = ph_sum[13:0];
    end
    unsafe = (ph_milli < min_ph_q) || (ph_milli > max_ph_q);
  end

  // Buzzer cycle: tone phase with one-second toggles, then a silent rest.
  logic [31:0] elapsed;

  always_comb begin
    alarm_d       = alarm_q;
    cycle_start_d = cycle_start_q;
    last_toggle_d = last_toggle_q;
    phase_d       = phase_q;
    buzz_d        = buzz_q;
    elapsed       = '0;
    if (!unsafe) begin
      alarm_d = 1'b0;
      buzz_d  = 1'b0;
    end else begin
      if (!alarm_q) begin
        alarm_d       = 1'b1;
        cycle_start_d = a_item_q.now_ms;
        last_toggle_d = a_item_q.now_ms;
        phase_d       = 1'b1;
        buzz_d        = 1'b1;
      end
      elapsed = a_item_q.now_ms - cycle_start_d;
      if (elapsed <= TONE_MS) begin
        if ((a_item_q.now_ms - last_toggle_d) >= TOGGLE_MS) begin
          phase_d       = !phase_d;
          buzz_d        = phase_d;
          last_toggle_d = a_item_q.now_ms;
        end
      end else if (elapsed <= CYCLE_MS) begin
        buzz_d = 1'b0;
      end else begin
        alarm_d = 1'b0;
      end
    end
  end

  // Result register and buzzer state advance together, one beat at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      alarm_q       <= 1'b0;
      cycle_start_q <= '0;
      last_toggle_q <= '0;
      phase_q       <= 1'b0;
      buzz_q        <= 1'b0;
    end else if (load_c) begin
      out_valid_q <= a_valid_q;
      if (a_valid_q) begin
        alarm_q       <= alarm_d;
        cycle_start_q <= cycle_start_d;
        last_toggle_q <= last_toggle_d;
        phase_q       <= phase_d;
        buzz_q        <= buzz_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_c && a_valid_q) begin
      out_item_q.ph_milli     <= ph_milli;
      out_item_q.ph_unsafe    <= unsafe;
      out_item_q.buzzer_on    <= buzz_d;
      out_item_q.led_red      <= leds.red;
      out_item_q.led_green    <= leds.green;
      out_item_q.led_blue     <= leds.blue;
      out_item_q.sensor_fault <= leds.fault;
    end
  end

  // Checks on the result and the buzzer state.
  a_ph_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.ph_milli <= 14'(PH_MAX)))
    else $error("pH result outside the saturation range");

  a_led_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({out_item_o.led_red, out_item_o.led_green,
                             out_item_o.led_blue, out_item_o.sensor_fault}))
    else $error("LED outputs are not exactly one of red, green, blue or fault");

  a_safe_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.ph_unsafe) |-> !out_item_o.buzzer_on)
    else $error("buzzer on with a safe pH");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load_c && a_valid_q) |=> ($stable(alarm_q) && $stable(buzz_q) && $stable(phase_q)))
    else $error("buzzer state changed without a sample moving to the output");

  a_buzz_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_c && a_valid_q) |=> (out_item_q.buzzer_on == buzz_q))
    else $error("result buzzer level differs from the buzzer state");

endmodule

`default_nettype wire
